// ----- design/mtm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtm_pkg
// Types and codes shared by the memory-to-memory operation unit.
// ----------------------------------------------------------------------------
package mtm_pkg;

    localparam int ADDR_W = 10;
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_NEG    = 3'd1,
        MODE_MUL    = 3'd2,
        MODE_READ   = 3'd3,
        MODE_ASSIGN = 3'd4,
        MODE_LE     = 3'd5
    } mode_e_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [2:0]               mode;
        logic [ADDR_W-1:0]        src_a_addr;
        logic [ADDR_W-1:0]        src_b_addr;
        logic [ADDR_W-1:0]        dest_addr;
        logic signed [WORD_W-1:0] immediate;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic                     bad_mode;
    } rsp_t;

    typedef struct packed {
        logic wr;
        rsp_t rsp;
    } alu_out_t;

    localparam logic [WORD_W-1:0] WORD_ALL_ONES = {WORD_W{1'b1}};

endpackage
`default_nettype wire

// ----- design/mtm_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtm_mem
// Data word memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mtm_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [AW-1:0]                 waddr,
    input  wire logic [mtm_pkg::WORD_W-1:0]    wdata,
    input  wire logic                          re,
    input  wire logic [AW-1:0]                 raddr_a,
    input  wire logic [AW-1:0]                 raddr_b,
    output logic      [mtm_pkg::WORD_W-1:0]    rdata_a,
    output logic      [mtm_pkg::WORD_W-1:0]    rdata_b
);

    logic [mtm_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
`default_nettype wire

// ----- design/mtm_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtm_alu
// Operation decode and arithmetic on the two source words.
// ----------------------------------------------------------------------------
module mtm_alu (
    input  wire logic [2:0]                        mode,
    input  wire logic [mtm_pkg::WORD_W-1:0]        a,
    input  wire logic [mtm_pkg::WORD_W-1:0]        b,
    input  wire logic [mtm_pkg::WORD_W-1:0]        imm,
    output mtm_pkg::alu_out_t                      res
);

    logic [mtm_pkg::WORD_W-1:0] sum;
    logic [mtm_pkg::WORD_W-1:0] neg;
    logic [mtm_pkg::WORD_W-1:0] prod;
    logic                       le;

    assign sum  = a + b;
    assign neg  = {mtm_pkg::WORD_W{1'b0}} - a;
    assign prod = a * b;
    assign le   = $signed(a) <= $signed(b);

    always_comb
    begin
        res.wr           = 1'b1;
        res.rsp.bad_mode = 1'b0;
        res.rsp.result   = '0;
        unique case (mtm_pkg::mode_e_t'(mode))
            mtm_pkg::MODE_ADD:    res.rsp.result = sum;
            mtm_pkg::MODE_NEG:    res.rsp.result = neg;
            mtm_pkg::MODE_MUL:    res.rsp.result = prod;
            mtm_pkg::MODE_READ:
            begin
                res.rsp.result = a;
                res.wr         = 1'b0;
            end
            mtm_pkg::MODE_ASSIGN: res.rsp.result = imm;
            mtm_pkg::MODE_LE:
                res.rsp.result = {{(mtm_pkg::WORD_W-1){1'b0}}, le};
            default:
            begin
                res.rsp.result   = mtm_pkg::WORD_ALL_ONES;
                res.rsp.bad_mode = 1'b1;
                res.wr           = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/memory_to_memory_op_unit_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// memory_to_memory_op_unit_top
// Runs one memory-to-memory operation per command word against a data
// memory of signed 32-bit words.
//
//   channel   handshake          payload
//   command   start / busy       cmd  (mtm_pkg::cmd_t)
//   response  done (1 cycle)     rsp  (mtm_pkg::rsp_t)
//
// A command is taken in idle with the registered dual-port memory read, then
// the operation and the write back run in the exec state. The response strobe
// follows in the next cycle, while the next command can already be taken.
// After reset busy stays high while the memory is cleared one word per cycle.
// done is never held off.
// ----------------------------------------------------------------------------
module memory_to_memory_op_unit_top #(
    parameter int MEM_WORDS = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire mtm_pkg::cmd_t cmd,
    output logic               done,
    output mtm_pkg::rsp_t      rsp
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int XW = (AW > mtm_pkg::ADDR_W) ? AW : mtm_pkg::ADDR_W;
    localparam int CW = XW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(MEM_WORDS);
    localparam logic [AW-1:0] LAST_C  = AW'(MEM_WORDS - 1);

    mtm_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            done_reg;

    logic [2:0]                 mode_reg;
    logic [AW-1:0]              dest_reg;
    logic [mtm_pkg::WORD_W-1:0] imm_reg;
    logic                       a_ok_reg, b_ok_reg, d_ok_reg;
    mtm_pkg::rsp_t              rsp_reg;

    logic          accept;
    logic          clr_we;
    logic          exec;
    logic [CW-1:0] ext_a, ext_b, ext_d;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [mtm_pkg::WORD_W-1:0] mem_wdata;
    logic [mtm_pkg::WORD_W-1:0] rd_a, rd_b;
    logic [mtm_pkg::WORD_W-1:0] op_a, op_b;
    mtm_pkg::alu_out_t          alu_res;

    assign accept = start && !busy;
    assign ext_a  = CW'(cmd.src_a_addr);
    assign ext_b  = CW'(cmd.src_b_addr);
    assign ext_d  = CW'(cmd.dest_addr);

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            mtm_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_C)
                begin
                    state_next = mtm_pkg::ST_IDLE;
                end
            end
            mtm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mtm_pkg::ST_EXEC;
                end
            end
            mtm_pkg::ST_EXEC: state_next = mtm_pkg::ST_IDLE;
            default:          state_next = mtm_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        busy   = 1'b1;
        clr_we = 1'b0;
        exec   = 1'b0;
        unique case (state_reg)
            mtm_pkg::ST_CLEAR: clr_we = 1'b1;
            mtm_pkg::ST_IDLE:  busy   = 1'b0;
            mtm_pkg::ST_EXEC:  exec   = 1'b1;
            default:           busy   = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtm_pkg::ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= exec;
        end
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= cmd.mode;
            dest_reg <= ext_d[AW-1:0];
            imm_reg  <= cmd.immediate;
            a_ok_reg <= ext_a < DEPTH_C;
            b_ok_reg <= ext_b < DEPTH_C;
            d_ok_reg <= ext_d < DEPTH_C;
        end
    end

    // out of range reads give zero
    assign op_a = a_ok_reg ? rd_a : '0;
    assign op_b = b_ok_reg ? rd_b : '0;

    mtm_alu u_alu (
        .mode (mode_reg),
        .a    (op_a),
        .b    (op_b),
        .imm  (imm_reg),
        .res  (alu_res)
    );

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            rsp_reg <= alu_res.rsp;
        end
    end

    assign mem_we    = clr_we || (exec && alu_res.wr && d_ok_reg);
    assign mem_waddr = clr_we ? clr_reg : dest_reg;
    assign mem_wdata = clr_we ? '0 : alu_res.rsp.result;

    mtm_mem #(
        .DEPTH (MEM_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (accept),
        .raddr_a (ext_a[AW-1:0]),
        .raddr_b (ext_b[AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the memory-to-memory operation unit. A directed run covers
// word extremes, every operation, wrap on add, negate and multiply, signed
// compare ties, overlapping addresses and both invalid modes. A random run
// follows, with addresses drawn mostly from a small pool so that reads see
// earlier writes. Every response is checked field by field against a
// memory model held in the testbench.
// ----------------------------------------------------------------------------
module tb;

    localparam int ADDR_W      = mtm_pkg::ADDR_W;
    localparam int WORD_W      = mtm_pkg::WORD_W;
    localparam int MEM_WORDS   = 1024;
    localparam int RAND_ITEMS  = 1500;
    localparam int STALL_LIMIT = 4 * MEM_WORDS;
    localparam logic [2:0] MODE_BAD_LO = 3'd6;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

    typedef struct {
        mtm_pkg::cmd_t word;
        bit            drain;
    } queued_cmd_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    mtm_pkg::cmd_t  cmd = '0;
    logic           busy;
    logic           done;
    mtm_pkg::rsp_t  rsp;

    queued_cmd_t       cmd_backlog[$];
    mtm_pkg::rsp_t     rsp_due[$];
    logic [WORD_W-1:0] mem_model [0:MEM_WORDS-1];
    bit                taken = 1'b0;
    int                n_total = 0;
    int                n_accepted = 0;
    int                n_checked = 0;
    int                n_errors = 0;
    int                idle_cycles = 0;
    int                mode_seen [8];

    memory_to_memory_op_unit_top #(.MEM_WORDS(MEM_WORDS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic mtm_pkg::rsp_t apply_cmd(mtm_pkg::cmd_t w);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] r;
        mtm_pkg::rsp_t     o;
        a = (w.src_a_addr < MEM_WORDS) ? mem_model[w.src_a_addr] : '0;
        b = (w.src_b_addr < MEM_WORDS) ? mem_model[w.src_b_addr] : '0;
        o.bad_mode = 1'b0;
        case (w.mode)
            mtm_pkg::MODE_ADD:    r = a + b;
            mtm_pkg::MODE_NEG:    r = '0 - a;
            mtm_pkg::MODE_MUL:    r = a * b;
            mtm_pkg::MODE_READ:   r = a;
            mtm_pkg::MODE_ASSIGN: r = w.immediate;
            mtm_pkg::MODE_LE:     r = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
            default:
            begin
                r = mtm_pkg::WORD_ALL_ONES;
                o.bad_mode = 1'b1;
            end
        endcase
        if (!o.bad_mode && w.mode != mtm_pkg::MODE_READ && w.dest_addr < MEM_WORDS)
            mem_model[w.dest_addr] = r;
        o.result = r;
        return o;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return ADDR_W'($urandom_range(0, 15));
        if (roll < 70)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return ADDR_W'(MEM_WORDS / 2 - 1);
                default: return ADDR_W'(MEM_WORDS / 2);
            endcase
        end
        return ADDR_W'($urandom_range(0, MEM_WORDS - 1));
    endfunction

    task automatic add_cmd(logic [2:0] mode, int a, int b, int d,
                           logic [WORD_W-1:0] imm, bit drain);
        queued_cmd_t q;
        q.word.mode       = mode;
        q.word.src_a_addr = ADDR_W'(a);
        q.word.src_b_addr = ADDR_W'(b);
        q.word.dest_addr  = ADDR_W'(d);
        q.word.immediate  = imm;
        q.drain           = drain;
        cmd_backlog.push_back(q);
        n_total++;
    endtask

    function automatic mtm_pkg::cmd_t random_cmd();
        mtm_pkg::cmd_t w;
        int            roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            w.mode = mtm_pkg::MODE_ASSIGN;
        else if (roll < 94)
            w.mode = 3'($urandom_range(0, 5));
        else
            w.mode = $urandom_range(0, 1) ? MODE_BAD_LO : MODE_BAD_HI;
        w.src_a_addr = pick_addr();
        w.src_b_addr = pick_addr();
        w.dest_addr  = pick_addr();
        roll = $urandom_range(0, 99);
        if (roll < 70)
            w.immediate = $urandom;
        else if (roll < 85)
            w.immediate = $signed(WORD_W'($urandom_range(0, 15))) - 8;
        else
            w.immediate = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
        return w;
    endfunction

    // driver
    always @(negedge clk)
    begin
        logic          go;
        mtm_pkg::cmd_t w;
        bit            calm;
        go = start;
        w = cmd;
        calm = (n_accepted >= 400 && n_accepted < 800);
        if (rst_n)
        begin
            if (start && taken)
            begin
                void'(cmd_backlog.pop_front());
                go = 1'b0;
            end
            if (!go && cmd_backlog.size() != 0)
            begin
                if (cmd_backlog[0].drain && rsp_due.size() != 0)
                    go = 1'b0;
                else if (!calm && $urandom_range(0, 99) < 10)
                    go = 1'b0;
                else
                begin
                    go = 1'b1;
                    w = cmd_backlog[0].word;
                end
            end
        end
        start <= go;
        cmd <= w;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        mtm_pkg::rsp_t want;
        taken = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response word with nothing outstanding: result %0d", rsp.result);
                    n_errors++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    n_checked++;
                    if (rsp.result !== want.result)
                    begin
                        $error("result: expected %0d, got %0d", want.result, rsp.result);
                        n_errors++;
                    end
                    if (rsp.bad_mode !== want.bad_mode)
                    begin
                        $error("bad_mode: expected %0b, got %0b", want.bad_mode,
                               rsp.bad_mode);
                        n_errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                taken = 1'b1;
                rsp_due.push_back(apply_cmd(cmd));
                mode_seen[cmd.mode]++;
                n_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < MEM_WORDS; i++)
            mem_model[i] = '0;

        // directed words
        add_cmd(mtm_pkg::MODE_ASSIGN, 0, 0, 0, WORD_MAX, 1'b0);
        add_cmd(mtm_pkg::MODE_ASSIGN, 0, 0, MEM_WORDS - 1, WORD_MIN, 1'b0);
        add_cmd(mtm_pkg::MODE_ASSIGN, 0, 0, 1, mtm_pkg::WORD_ALL_ONES, 1'b0);
        add_cmd(mtm_pkg::MODE_ASSIGN, 0, 0, 2, 32'd1, 1'b0);
        add_cmd(mtm_pkg::MODE_ADD, 0, 2, 3, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_NEG, MEM_WORDS - 1, 0, 4, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_MUL, 0, 0, 5, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_MUL, MEM_WORDS - 1, 1, 6, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_LE, MEM_WORDS - 1, 0, 7, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_LE, 0, MEM_WORDS - 1, 8, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_LE, 2, 2, 9, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_READ, MEM_WORDS - 1, 0, 0, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_READ, 500, 0, 0, '0, 1'b0);
        add_cmd(MODE_BAD_LO, MEM_WORDS - 1, MEM_WORDS - 1, MEM_WORDS - 1,
                mtm_pkg::WORD_ALL_ONES, 1'b0);
        add_cmd(MODE_BAD_HI, 0, 0, 0, WORD_MAX, 1'b0);
        add_cmd(mtm_pkg::MODE_READ, 0, 0, 0, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_ADD, 0, 0, 0, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_NEG, 3, 0, 3, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_MUL, 1, 1, 1, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_ASSIGN, 0, 0, MEM_WORDS - 1, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_READ, 0, 0, 0, '0, 1'b1);
        add_cmd(mtm_pkg::MODE_ASSIGN, 0, 0, 0, 32'h5555_5555, 1'b0);
        add_cmd(mtm_pkg::MODE_ADD, 0, MEM_WORDS - 1, MEM_WORDS - 1, '0, 1'b0);
        add_cmd(mtm_pkg::MODE_LE, 4, 3, 10, '0, 1'b0);

        // random words, with a full drain now and then
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            queued_cmd_t q;
            q.word = random_cmd();
            q.drain = (i % 250 == 125);
            cmd_backlog.push_back(q);
            n_total++;
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_total)
            @(posedge clk);
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (rsp_due.size() != 0)
        begin
            $error("%0d response words never arrived", rsp_due.size());
            n_errors++;
        end

        $display("summary: %0d commands sent, %0d responses checked, %0d mismatches",
                 n_accepted, n_checked, n_errors);
        $display("summary: add %0d neg %0d mul %0d read %0d assign %0d le %0d invalid %0d",
                 mode_seen[mtm_pkg::MODE_ADD], mode_seen[mtm_pkg::MODE_NEG],
                 mode_seen[mtm_pkg::MODE_MUL], mode_seen[mtm_pkg::MODE_READ],
                 mode_seen[mtm_pkg::MODE_ASSIGN], mode_seen[mtm_pkg::MODE_LE],
                 mode_seen[MODE_BAD_LO] + mode_seen[MODE_BAD_HI]);
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mtm_pkg.sv
design/mtm_mem.sv
design/mtm_alu.sv
design/memory_to_memory_op_unit_top.sv
dv/tb.sv
